[design/tbc_pkg.sv]
// shared constants and types for the trimmed blob centroid core
// no dependencies
package tbc_pkg;

  localparam int MAX_PIXELS  = 256;
  localparam int COORD_BITS  = 11;
  localparam int FRAC_BITS   = 8;
  localparam int ADDR_W      = $clog2(MAX_PIXELS);
  localparam int CNT_W       = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W       = COORD_BITS + ADDR_W;
  localparam int NX_W        = COORD_BITS + CNT_W;
  localparam int DIST_W      = 2 * NX_W + 1;
  localparam int CENTER_W    = 19;
  localparam int KEEP_W      = 7;
  localparam int QUO_W       = SUM_W + FRAC_BITS;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int PROD_W      = CNT_W + KEEP_W;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam int RPROD_W     = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = 13'd5243;
  localparam logic [KEEP_W-1:0]  KEEP_RESET = 7'd85;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  store;
    logic                  last;
    logic                  dropped;
  } pix_word_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [CNT_W-1:0]    kept_count;
    logic                overflowed;
  } result_t;

endpackage

[design/tbc_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module tbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/tbc_front.sv]
// front end: takes pixel words, classifies them as stored or dropped
// depends on tbc_pkg
module tbc_front
  import tbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  full,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic                  last_pixel,
  output logic                  push,
  output pix_word_t             word
);

  logic [CNT_W-1:0] count;
  logic             drop_flag;
  logic             fits;

  assign push         = start && !full;
  assign fits         = (count < CNT_W'(MAX_PIXELS));
  assign word.x       = pixel_x;
  assign word.y       = pixel_y;
  assign word.store   = fits;
  assign word.last    = last_pixel;
  assign word.dropped = drop_flag || !fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      drop_flag <= 1'b0;
    end else if (push) begin
      if (last_pixel) begin
        count     <= '0;
        drop_flag <= 1'b0;
      end else if (fits) begin
        count <= count + 1'b1;
      end else begin
        drop_flag <= 1'b1;
      end
    end
  end

endmodule

[design/tbc_queue.sv]
// short word queue between front and back end
// depends on tbc_pkg
module tbc_queue
  import tbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pix_word_t push_word,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output pix_word_t head
);

  pix_word_t           slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     fill;

  assign full  = (fill == (QPTR_W+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[design/tbc_div.sv]
// restoring divider, one quotient bit per cycle
// depends on tbc_pkg
module tbc_div
  import tbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QUO_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient,
  output logic             done
);

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [STEP_W-1:0] steps;
  logic              running;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    shifted;
  logic              fits;

  assign shifted = {rem, quotient[QUO_W-1]};
  assign fits    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        steps    <= STEP_W'(QUO_W);
        rem      <= '0;
        quotient <= dividend;
      end else if (running) begin
        if (fits) begin
          rem <= CNT_W'(shifted - {1'b0, divisor});
        end else begin
          rem <= shifted[CNT_W-1:0];
        end
        quotient <= {quotient[QUO_W-2:0], fits};
        steps    <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

[design/tbc_back.sv]
// back end: pixel store, distance pass, exchange sort and trimmed mean
// depends on tbc_pkg, tbc_ram, tbc_div
module tbc_back
  import tbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  pix_word_t         head,
  input  logic [KEEP_W-1:0] keep_percent,
  output logic              pop,
  output logic              done,
  output result_t           result
);

  typedef enum logic [3:0] {
    IDLE, KEEP1, KEEP2, KEEP3, DIST_RD, DIST_MUL, DIST_DIF, DIST_SQ, DIST_WR,
    SORT_LD, SORT_FIRST, SORT_CMP, ACC, DIV_GO, DIV_WAIT
  } state_t;

  state_t state;

  logic [CNT_W-1:0]       n, kept, k, i, j;
  logic [SUM_W-1:0]       sx, sy, ax, ay;
  logic                   dropped;
  logic [PROD_W-1:0]      prod;
  logic [RPROD_W-1:0]     rprod;
  logic [CNT_W:0]         q;
  logic [NX_W-1:0]        nx, ny, dx, dy;
  logic [2*NX_W-1:0]      sqx, sqy;
  logic [DIST_W-1:0]      cur_d;
  logic [COORD_BITS-1:0]  cur_x, cur_y;

  logic                   we_xy, we_d;
  logic [ADDR_W-1:0]      waddr, raddr;
  logic [COORD_BITS-1:0]  wx, wy, rx, ry;
  logic [DIST_W-1:0]      wd, rd;
  logic                   div_start, done_x, done_y, got_x, got_y;
  logic [QUO_W-1:0]       quo_x, quo_y;
  logic                   swap;

  assign pop  = (state == IDLE) && !empty;
  assign swap = (state == SORT_CMP) && (cur_d > rd);
  assign q    = rprod[RECIP_SHIFT +: CNT_W+1];

  always_comb begin
    we_xy = 1'b0;
    we_d  = 1'b0;
    waddr = n[ADDR_W-1:0];
    wx    = head.x;
    wy    = head.y;
    wd    = DIST_W'(sqx) + DIST_W'(sqy);
    case (state)
      IDLE: begin
        we_xy = pop && head.store;
      end
      DIST_WR: begin
        we_d  = 1'b1;
        waddr = k[ADDR_W-1:0];
      end
      SORT_CMP: begin
        we_xy = swap;
        we_d  = swap;
        waddr = j[ADDR_W-1:0];
        wx    = cur_x;
        wy    = cur_y;
        wd    = cur_d;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (state)
      SORT_LD:    raddr = i[ADDR_W-1:0];
      SORT_FIRST: raddr = ADDR_W'(i + 1'b1);
      SORT_CMP:   raddr = ADDR_W'(j + 1'b1);
      default:    raddr = k[ADDR_W-1:0];
    endcase
  end

  tbc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PIXELS)) u_col (
    .clk(clk), .we(we_xy), .waddr(waddr), .wdata(wx), .raddr(raddr), .rdata(rx)
  );
  tbc_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_PIXELS)) u_row (
    .clk(clk), .we(we_xy), .waddr(waddr), .wdata(wy), .raddr(raddr), .rdata(ry)
  );
  tbc_ram #(.WIDTH(DIST_W), .DEPTH(MAX_PIXELS)) u_dist (
    .clk(clk), .we(we_d), .waddr(waddr), .wdata(wd), .raddr(raddr), .rdata(rd)
  );

  tbc_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .dividend({ax, FRAC_BITS'(0)}),
    .divisor(kept), .quotient(quo_x), .done(done_x)
  );
  tbc_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .dividend({ay, FRAC_BITS'(0)}),
    .divisor(kept), .quotient(quo_y), .done(done_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      n         <= '0;
      sx        <= '0;
      sy        <= '0;
      dropped   <= 1'b0;
      done      <= 1'b0;
      div_start <= 1'b0;
      got_x     <= 1'b0;
      got_y     <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      case (state)
        IDLE: begin
          if (pop) begin
            if (head.store) begin
              n  <= n + 1'b1;
              sx <= sx + SUM_W'(head.x);
              sy <= sy + SUM_W'(head.y);
            end
            if (head.last) begin
              dropped <= head.dropped;
              if (head.store) begin
                n  <= n + 1'b1;
                sx <= sx + SUM_W'(head.x);
                sy <= sy + SUM_W'(head.y);
              end
              state <= KEEP1;
            end
          end
        end
        KEEP1: begin
          prod  <= PROD_W'(n) * PROD_W'(keep_percent);
          state <= KEEP2;
        end
        KEEP2: begin
          rprod <= RPROD_W'(prod) * RPROD_W'(RECIP);
          state <= KEEP3;
        end
        KEEP3: begin
          if (q == '0) begin
            kept <= CNT_W'(1);
          end else if (q > {1'b0, n}) begin
            kept <= n;
          end else begin
            kept <= q[CNT_W-1:0];
          end
          k     <= '0;
          state <= DIST_RD;
        end
        DIST_RD: begin
          state <= DIST_MUL;
        end
        DIST_MUL: begin
          nx    <= NX_W'(n) * NX_W'(rx);
          ny    <= NX_W'(n) * NX_W'(ry);
          state <= DIST_DIF;
        end
        DIST_DIF: begin
          dx    <= (nx > NX_W'(sx)) ? nx - NX_W'(sx) : NX_W'(sx) - nx;
          dy    <= (ny > NX_W'(sy)) ? ny - NX_W'(sy) : NX_W'(sy) - ny;
          state <= DIST_SQ;
        end
        DIST_SQ: begin
          sqx   <= dx * dx;
          sqy   <= dy * dy;
          state <= DIST_WR;
        end
        DIST_WR: begin
          if (k == n - 1'b1) begin
            i     <= '0;
            ax    <= '0;
            ay    <= '0;
            state <= SORT_LD;
          end else begin
            k     <= k + 1'b1;
            state <= DIST_RD;
          end
        end
        SORT_LD: begin
          state <= SORT_FIRST;
        end
        SORT_FIRST: begin
          cur_d <= rd;
          cur_x <= rx;
          cur_y <= ry;
          j     <= i + 1'b1;
          if (i == n - 1'b1) begin
            state <= ACC;
          end else begin
            state <= SORT_CMP;
          end
        end
        SORT_CMP: begin
          if (swap) begin
            cur_d <= rd;
            cur_x <= rx;
            cur_y <= ry;
          end
          if (j == n - 1'b1) begin
            state <= ACC;
          end else begin
            j <= j + 1'b1;
          end
        end
        ACC: begin
          ax <= ax + SUM_W'(cur_x);
          ay <= ay + SUM_W'(cur_y);
          i  <= i + 1'b1;
          if (i + 1'b1 == kept) begin
            state <= DIV_GO;
          end else begin
            state <= SORT_LD;
          end
        end
        DIV_GO: begin
          div_start <= 1'b1;
          got_x     <= 1'b0;
          got_y     <= 1'b0;
          state     <= DIV_WAIT;
        end
        DIV_WAIT: begin
          if (done_x) begin
            got_x           <= 1'b1;
            result.center_x <= quo_x[CENTER_W-1:0];
          end
          if (done_y) begin
            got_y           <= 1'b1;
            result.center_y <= quo_y[CENTER_W-1:0];
          end
          if ((got_x || done_x) && (got_y || done_y)) begin
            result.kept_count <= kept;
            result.overflowed <= dropped;
            done              <= 1'b1;
            n                 <= '0;
            sx                <= '0;
            sy                <= '0;
            dropped           <= 1'b0;
            state             <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[design/trimmed_blob_centroid_core.sv]
// top level of the trimmed blob centroid core with its register port
// depends on tbc_pkg, tbc_front, tbc_queue, tbc_back

// Pixels are taken one word per cycle while busy is low. A four word queue sits
// in front of the compute engine, which pops one word per cycle and stops popping
// while it works on a closed blob; busy rises once the queue holds four words.
// After popping the closing word the engine works out the kept count, computes
// the distances, runs the exchange sort (one compare per cycle, stopping once the
// kept pixels are in place) and the two dividers, then pulses done for one cycle
// with the result; the result cannot be held off. Store depth is 256 pixels.
module trimmed_blob_centroid_core
  import tbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic                  last_pixel,
  output logic                  done,
  output logic [CENTER_W-1:0]   center_x,
  output logic [CENTER_W-1:0]   center_y,
  output logic [CNT_W-1:0]      kept_count,
  output logic                  overflowed
);

  logic [KEEP_W-1:0] keep_percent;
  logic              push, pop, full, empty;
  pix_word_t         push_word, head;
  result_t           result;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? 32'(keep_percent) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_percent <= KEEP_RESET;
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      keep_percent <= pwdata[KEEP_W-1:0];
    end
  end

  assign busy = full;

  tbc_front u_front (
    .clk(clk), .rst(rst), .start(start), .full(full), .pixel_x(pixel_x),
    .pixel_y(pixel_y), .last_pixel(last_pixel), .push(push), .word(push_word)
  );

  tbc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_word(push_word), .pop(pop),
    .full(full), .empty(empty), .head(head)
  );

  tbc_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .head(head), .keep_percent(keep_percent),
    .pop(pop), .done(done), .result(result)
  );

  assign center_x   = result.center_x;
  assign center_y   = result.center_y;
  assign kept_count = result.kept_count;
  assign overflowed = result.overflowed;

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result word on two cycles running");
  a_kept_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (kept_count != '0 && kept_count <= CNT_W'(MAX_PIXELS)))
    else $error("kept count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");

endmodule

[test/trimmed_blob_centroid_core_tb.sv]
// testbench for trimmed_blob_centroid_core: loads blobs one pixel word at a time,
// predicts each trimmed centroid with a scoreboard class and checks every result
// depends on tbc_pkg and the core's rtl
module trimmed_blob_centroid_core_tb;
  import tbc_pkg::*;

  class centroid_scoreboard;
    int unsigned keep_pct;
    logic [COORD_BITS-1:0] col[MAX_PIXELS];
    logic [COORD_BITS-1:0] row[MAX_PIXELS];
    int unsigned stored;
    bit dropped;
    result_t expected_q[$];
    int errors;

    function new();
      keep_pct = KEEP_RESET;
      stored = 0;
      dropped = 0;
      errors = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    function longint unsigned sq_gap(longint unsigned a, longint unsigned b);
      longint unsigned g;
      g = (a > b) ? a - b : b - a;
      return g * g;
    endfunction

    function logic [CENTER_W-1:0] mean_of(longint unsigned sum, int unsigned kept);
      longint unsigned q;
      q = (sum << FRAC_BITS) / kept;
      return q[CENTER_W-1:0];
    endfunction

    function void note_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y, logic last);
      longint unsigned sx, sy, kx, ky, td;
      longint unsigned gaps[MAX_PIXELS];
      logic [COORD_BITS-1:0] tc;
      int unsigned n, kept;
      result_t r;
      if (stored < MAX_PIXELS) begin
        col[stored] = x;
        row[stored] = y;
        stored++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      n = stored;
      sx = 0;
      sy = 0;
      for (int i = 0; i < n; i++) begin
        sx += col[i];
        sy += row[i];
      end
      for (int i = 0; i < n; i++)
        gaps[i] = sq_gap(n * longint'(col[i]), sx) + sq_gap(n * longint'(row[i]), sy);
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++)
          if (gaps[i] > gaps[j]) begin
            td = gaps[i]; gaps[i] = gaps[j]; gaps[j] = td;
            tc = col[i]; col[i] = col[j]; col[j] = tc;
            tc = row[i]; row[i] = row[j]; row[j] = tc;
          end
      kept = (n * keep_pct) / 100;
      if (kept == 0) kept = 1;
      if (kept > n) kept = n;
      kx = 0;
      ky = 0;
      for (int i = 0; i < kept; i++) begin
        kx += col[i];
        ky += row[i];
      end
      r.center_x = mean_of(kx, kept);
      r.center_y = mean_of(ky, kept);
      r.kept_count = kept[CNT_W-1:0];
      r.overflowed = dropped;
      expected_q = {expected_q, r};
      stored = 0;
      dropped = 0;
    endfunction

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result, center_x", got.center_x, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.center_x !== want.center_x) report("center_x", got.center_x, want.center_x);
      if (got.center_y !== want.center_y) report("center_y", got.center_y, want.center_y);
      if (got.kept_count !== want.kept_count)
        report("kept_count", got.kept_count, want.kept_count);
      if (got.overflowed !== want.overflowed)
        report("overflowed", got.overflowed, want.overflowed);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic start = 0;
  logic busy;
  logic [COORD_BITS-1:0] pixel_x = 0, pixel_y = 0;
  logic last_pixel = 0;
  logic done;
  logic [CENTER_W-1:0] center_x, center_y;
  logic [CNT_W-1:0] kept_count;
  logic overflowed;

  localparam logic [2:0] KEEP_ADDR = 3'd0;
  localparam int SETTLE = 200;

  centroid_scoreboard sb = new();
  int idle_pct;
  int sent;

  trimmed_blob_centroid_core dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_pixel(pixel_x, pixel_y, last_pixel);
    if (!rst && done) sb.check_result('{center_x, center_y, kept_count, overflowed});
  end

  task send_pixel(int x, int y, bit last);
    while ($urandom_range(99) < idle_pct) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    pixel_x = x;
    pixel_y = y;
    last_pixel = last;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
    sent++;
  endtask

  task wait_drained();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task write_keep(int value);
    wait_drained();
    psel = 1;
    pwrite = 1;
    paddr = KEEP_ADDR;
    pwdata = value;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
    sb.keep_pct = value & 7'h7f;
  endtask

  function int clamp(int v);
    return v < 0 ? 0 : (v > 2047 ? 2047 : v);
  endfunction

  task send_blob(int n);
    int cx, cy, spread, x, y, px, py;
    cx = $urandom_range(2047);
    cy = $urandom_range(2047);
    spread = $urandom_range(1) ? $urandom_range(8) : $urandom_range(300);
    px = cx;
    py = cy;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: begin x = $urandom_range(2047); y = $urandom_range(2047); end
        1: begin x = px; y = py; end
        default: begin
          x = clamp(cx + int'($urandom_range(2 * spread)) - spread);
          y = clamp(cy + int'($urandom_range(2 * spread)) - spread);
        end
      endcase
      px = x;
      py = y;
      send_pixel(x, y, i == n - 1);
    end
  endtask

  initial begin
    int keeps[8] = '{85, 0, 1, 100, 127, 50, 99, 73};
    int phase_end;
    idle_pct = 0;
    sent = 0;
    repeat (9) @(negedge clk);
    rst = 0;
    @(negedge clk);
    // directed words at reset setting
    send_pixel(0, 0, 1);
    send_pixel(2047, 2047, 1);
    send_pixel(0, 2047, 0);
    send_pixel(2047, 0, 1);
    send_pixel(10, 10, 0);
    send_pixel(12, 10, 0);
    send_pixel(8, 10, 0);
    send_pixel(10, 12, 0);
    send_pixel(10, 8, 1);
    send_pixel(5, 5, 0);
    send_pixel(5, 5, 0);
    send_pixel(5, 5, 1);
    write_keep(0);
    send_pixel(100, 200, 0);
    send_pixel(300, 400, 0);
    send_pixel(1000, 2000, 1);
    write_keep(127);
    send_pixel(1, 2, 0);
    send_pixel(1365, 682, 1);
    write_keep(100);
    send_pixel(2047, 1, 0);
    send_pixel(1, 2047, 1);
    // random blobs over several settings and idle mixes
    for (int p = 0; p < 8; p++) begin
      write_keep(p == 0 ? 85 : (p < 5 ? keeps[p] : $urandom_range(127)));
      case (p % 4)
        0: idle_pct = 0;
        1: idle_pct = 45;
        2: idle_pct = 0;
        default: idle_pct = 22;
      endcase
      if (p == 2) send_blob(MAX_PIXELS + $urandom_range(1, 4));
      if (p == 6) send_blob(MAX_PIXELS);
      phase_end = sent + 35;
      while (sent < phase_end)
        send_blob($urandom_range(3) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12));
    end
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0) begin
      $display("trimmed_blob_centroid_core_tb passed");
    end else begin
      $display("trimmed_blob_centroid_core_tb failed");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("trimmed_blob_centroid_core_tb failed");
    $finish;
  end

endmodule

[filelist.f]
design/tbc_pkg.sv
design/tbc_ram.sv
design/tbc_front.sv
design/tbc_queue.sv
design/tbc_div.sv
design/tbc_back.sv
design/trimmed_blob_centroid_core.sv
test/trimmed_blob_centroid_core_tb.sv
